// ===== design/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sgmc_pkg.sv =====
package sgmc_pkg;

  // Event kinds carried on the input tuser
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_ECHO = 2'd1,
    ACT_CMD  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  // Configuration register indexes
  localparam logic [1:0] REG_TRIGGER_PERIOD = 2'd0;
  localparam logic [1:0] REG_STOP_DISTANCE  = 2'd1;
  localparam logic [1:0] REG_BLINK_SCALE    = 2'd2;

  // Configuration reset values
  localparam logic [15:0] TRIGGER_PERIOD_RST = 16'd3390;
  localparam logic [15:0] STOP_DISTANCE_RST  = 16'd10;
  localparam logic [7:0]  BLINK_SCALE_RST    = 8'd90;

  // Command characters
  localparam logic [7:0] CMD_FWD   = 8'h77;
  localparam logic [7:0] CMD_BACK  = 8'h73;
  localparam logic [7:0] CMD_LEFT  = 8'h61;
  localparam logic [7:0] CMD_RIGHT = 8'h64;
  localparam logic [7:0] CMD_STOP  = 8'h71;
  localparam logic [7:0] CMD_SP60  = 8'h36;
  localparam logic [7:0] CMD_SP80  = 8'h38;
  localparam logic [7:0] CMD_SP100 = 8'h30;

  // H-bridge patterns
  localparam logic [3:0] DRIVE_FWD   = 4'd5;
  localparam logic [3:0] DRIVE_BACK  = 4'd10;
  localparam logic [3:0] DRIVE_LEFT  = 4'd9;
  localparam logic [3:0] DRIVE_RIGHT = 4'd6;
  localparam logic [3:0] DRIVE_STOP  = 4'd0;

  // PWM compare values
  localparam logic [7:0] DUTY_60  = 8'h99;
  localparam logic [7:0] DUTY_80  = 8'hCC;
  localparam logic [7:0] DUTY_100 = 8'hFF;

  // Saturation limits
  localparam logic [15:0] ECHO_MAX  = 16'hFFFF;
  localparam logic [23:0] BLINK_MAX = 24'hFF_FFFF;

  // One result beat
  typedef struct packed {
    logic        obstacle;
    logic [15:0] distance;
    logic        led;
    logic [7:0]  duty_compare;
    logic [3:0]  motor_drive;
    logic        trigger;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_DATA_W = 32;

endpackage

// ===== design/sgmc_core.sv =====
module sgmc_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data,
  input  logic                    in_fire,
  input  sgmc_pkg::action_t       action,
  input  logic                    echo_level,
  input  logic [7:0]              cmd_byte,
  output sgmc_pkg::result_t       result
);
  import sgmc_pkg::*;

  logic [15:0] trigger_period;
  logic [15:0] stop_distance;
  logic [7:0]  blink_scale;

  logic [15:0] trigger_count, trigger_count_next;
  logic        trigger_reg, trigger_reg_next;
  logic [15:0] echo_count, echo_count_next;
  logic        measuring, measuring_next;
  logic [15:0] range_value, range_value_next;
  logic [7:0]  command_reg, command_reg_next;
  logic [3:0]  drive_reg, drive_reg_next;
  logic [7:0]  duty_reg, duty_reg_next;
  logic [23:0] blink_count, blink_count_next;
  logic        led_reg, led_reg_next;

  logic [15:0] trigger_inc;
  logic [23:0] blink_mid;
  logic [23:0] blink_limit;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_period <= TRIGGER_PERIOD_RST;
      stop_distance  <= STOP_DISTANCE_RST;
      blink_scale    <= BLINK_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_PERIOD: trigger_period <= cfg_data;
        REG_STOP_DISTANCE:  stop_distance  <= cfg_data;
        REG_BLINK_SCALE:    blink_scale    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Apply the event of this beat
  always_comb begin
    trigger_inc        = trigger_count + 16'd1;
    trigger_count_next = trigger_count;
    trigger_reg_next   = trigger_reg;
    echo_count_next    = echo_count;
    measuring_next     = measuring;
    range_value_next   = range_value;
    command_reg_next   = command_reg;
    blink_mid          = blink_count;
    case (action)
      ACT_TICK: begin
        if (trigger_inc >= trigger_period) begin
          trigger_count_next = '0;
          trigger_reg_next   = 1'b1;
        end else begin
          trigger_count_next = trigger_inc;
          trigger_reg_next   = 1'b0;
        end
        if (measuring && echo_count != ECHO_MAX) begin
          echo_count_next = echo_count + 16'd1;
        end
        if (blink_count != BLINK_MAX) begin
          blink_mid = blink_count + 24'd1;
        end
      end
      ACT_ECHO: begin
        if (echo_level) begin
          echo_count_next = '0;
          measuring_next  = 1'b1;
        end else begin
          range_value_next = echo_count;
          measuring_next   = 1'b0;
        end
      end
      ACT_CMD: begin
        command_reg_next = cmd_byte;
      end
      default: ;
    endcase
  end

  // Toggle the LED once the blink count reaches distance times scale
  assign blink_limit = {8'd0, range_value_next} * {16'd0, blink_scale};

  always_comb begin
    if (blink_mid >= blink_limit) begin
      blink_count_next = '0;
      led_reg_next     = ~led_reg;
    end else begin
      blink_count_next = blink_mid;
      led_reg_next     = led_reg;
    end
  end

  // Select the bridge pattern and duty from the held command
  always_comb begin
    drive_reg_next = drive_reg;
    duty_reg_next  = duty_reg;
    case (command_reg_next)
      CMD_FWD:   drive_reg_next = (range_value_next >= stop_distance) ? DRIVE_FWD : DRIVE_STOP;
      CMD_BACK:  drive_reg_next = DRIVE_BACK;
      CMD_LEFT:  drive_reg_next = DRIVE_LEFT;
      CMD_RIGHT: drive_reg_next = DRIVE_RIGHT;
      CMD_STOP:  drive_reg_next = DRIVE_STOP;
      CMD_SP60:  duty_reg_next  = DUTY_60;
      CMD_SP80:  duty_reg_next  = DUTY_80;
      CMD_SP100: duty_reg_next  = DUTY_100;
      default: ;
    endcase
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_count <= '0;
      trigger_reg   <= 1'b0;
      echo_count    <= '0;
      measuring     <= 1'b0;
      range_value   <= '0;
      command_reg   <= CMD_STOP;
      drive_reg     <= DRIVE_STOP;
      duty_reg      <= DUTY_60;
      blink_count   <= '0;
      led_reg       <= 1'b0;
    end else if (in_fire) begin
      trigger_count <= trigger_count_next;
      trigger_reg   <= trigger_reg_next;
      echo_count    <= echo_count_next;
      measuring     <= measuring_next;
      range_value   <= range_value_next;
      command_reg   <= command_reg_next;
      drive_reg     <= drive_reg_next;
      duty_reg      <= duty_reg_next;
      blink_count   <= blink_count_next;
      led_reg       <= led_reg_next;
    end
  end

  // Result of this beat, taken from the updated state
  always_comb begin
    result.trigger      = trigger_reg_next;
    result.motor_drive  = drive_reg_next;
    result.duty_compare = duty_reg_next;
    result.led          = led_reg_next;
    result.distance     = range_value_next;
    result.obstacle     = (range_value_next < stop_distance);
  end

endmodule

// ===== design/sgmc_skid.sv =====
module sgmc_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sgmc_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sgmc_pkg::result_t out_data
);
  import sgmc_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  // Take a new beat whenever the spare slot is empty
  assign in_ready = ~skid_valid;

  // Output register with one spare slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Move payload without reset
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end
    if (!skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

// ===== design/sonar_guarded_motor_controller.sv =====
// Sonar-guarded motor controller. Each input beat is one event (tuser: 0 timer
// tick, 1 echo edge, 2 command byte, 3 no event) and yields exactly one result
// beat carrying trigger level, H-bridge pattern, PWM compare, LED level,
// latched distance and obstacle flag. A beat is accepted every clock while the
// spare slot is empty; its result is registered at the output. Two result
// slots sit at the output, so the input stays ready while one result waits
// and stalls only once both are full. Throughput is one beat per cycle while
// the output is not stalled; the clock rate is set by the LED check, a 16x8
// multiply of distance by blink_scale feeding a 24-bit compare in the same
// cycle. Configuration writes (index 0 trigger_period, 1 stop_distance, 2
// blink_scale) belong to idle periods.
module sonar_guarded_motor_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [0] echo_level, [8:1] cmd_byte, rest zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // [0] trigger, [4:1] motor_drive,
                                     // [12:5] duty_compare, [13] led,
                                     // [29:14] distance, [30] obstacle, [31] zero
);
  import sgmc_pkg::*;

  logic    in_fire;
  result_t core_result;
  result_t out_result;

  assign in_fire = s_axis_tvalid & s_axis_tready;

  // Event state and result logic
  sgmc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_fire    (in_fire),
    .action     (action_t'(s_axis_tuser)),
    .echo_level (s_axis_tdata[0]),
    .cmd_byte   (s_axis_tdata[8:1]),
    .result     (core_result)
  );

  // Output buffering
  sgmc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (core_result),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_result)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_result};

endmodule

// ===== design/sgmc_checker.sv =====
`include "assert_macros.svh"

module sgmc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  import sgmc_pkg::*;

  logic [3:0] drive_bits;
  logic [7:0] duty_bits;
  logic       drive_ok;
  logic       duty_ok;

  // Split the bridge and duty fields out of the result beat
  assign drive_bits = m_axis_tdata[4:1];
  assign duty_bits  = m_axis_tdata[12:5];

  assign drive_ok = (drive_bits == DRIVE_STOP) || (drive_bits == DRIVE_FWD) ||
                    (drive_bits == DRIVE_BACK) || (drive_bits == DRIVE_LEFT) ||
                    (drive_bits == DRIVE_RIGHT);
  assign duty_ok  = (duty_bits == DUTY_60) || (duty_bits == DUTY_80) ||
                    (duty_bits == DUTY_100);

  // No result may leave right after reset
  `ASSERT_CLK_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "result valid after reset")

  // Bridge pattern is one of the five known ones
  `ASSERT_CLK(a_drive_legal, m_axis_tvalid |-> drive_ok, "illegal bridge pattern")

  // Compare value is one of the three speeds
  `ASSERT_CLK(a_duty_legal, m_axis_tvalid |-> duty_ok, "illegal duty value")

  // Stalled result beat holds
  `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")

endmodule

bind sonar_guarded_motor_controller sgmc_checker u_checker (.*);

// ===== verif/sonar_guarded_motor_controller_tb.sv =====
`timescale 1ns / 100ps

module sonar_guarded_motor_controller_tb;
  import sgmc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 118;

  // Directed table rows: one event repeated, or a register write
  typedef enum {ROW_EVT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    action_t     act;
    logic        lvl;
    logic [7:0]  cmd;
    int          reps;
    bit          fixed;
    result_t     want;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [0] echo_level, [8:1] cmd_byte, rest zero
  logic [1:0]  s_axis_tuser = '0;  // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // [0] trigger, [4:1] motor_drive, [12:5] duty_compare,
                                   // [13] led, [29:14] distance, [30] obstacle, [31] zero

  // Shadow copy of the controller registers and state
  logic [15:0] period_cfg, stop_cfg;
  logic [7:0]  scale_cfg;
  logic [15:0] trig_cnt, echo_cnt, dist_q;
  logic        echo_on, led_q, trig_q;
  logic [7:0]  cmd_q, duty_q;
  logic [3:0]  drive_q;
  logic [23:0] blink_cnt;

  result_t pending_status[$];
  row_t    dir_rows[$];

  bit      fixed_on = 1'b0;
  result_t fixed_status = '0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      mismatches = 0;
  int      events_in = 0;
  int      beats_out = 0;
  int      cycle_cnt = 0;

  // Random sequence state: an open echo pulse and its target width
  bit      gen_meas = 1'b0;
  int      gen_goal = 0;
  int      gen_ticks = 0;

  sonar_guarded_motor_controller dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  // Receiver backpressure
  always @(negedge clk) begin
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  task automatic reset_model();
    period_cfg = TRIGGER_PERIOD_RST;
    stop_cfg   = STOP_DISTANCE_RST;
    scale_cfg  = BLINK_SCALE_RST;
    trig_cnt   = '0;
    echo_cnt   = '0;
    dist_q     = '0;
    echo_on    = 1'b0;
    led_q      = 1'b0;
    trig_q     = 1'b0;
    cmd_q      = CMD_STOP;
    drive_q    = DRIVE_STOP;
    duty_q     = DUTY_60;
    blink_cnt  = '0;
  endtask

  // Apply one event to the shadow state and return the status beat it yields
  function automatic result_t compute_status(action_t act, logic lvl, logic [7:0] cmd);
    result_t     r;
    logic [31:0] blink_limit;
    case (act)
      ACT_TICK: begin
        trig_cnt = trig_cnt + 16'd1;
        if (trig_cnt >= period_cfg) begin
          trig_cnt = '0;
          trig_q = 1'b1;
        end else begin
          trig_q = 1'b0;
        end
        if (echo_on && echo_cnt != ECHO_MAX) echo_cnt = echo_cnt + 16'd1;
        if (blink_cnt != BLINK_MAX) blink_cnt = blink_cnt + 24'd1;
      end
      ACT_ECHO: begin
        if (lvl) begin
          echo_cnt = '0;
          echo_on = 1'b1;
        end else begin
          dist_q = echo_cnt;
          echo_on = 1'b0;
        end
      end
      ACT_CMD: cmd_q = cmd;
      default: ;
    endcase

    // LED check uses the full product, no wrap
    blink_limit = 32'(dist_q) * 32'(scale_cfg);
    if (32'(blink_cnt) >= blink_limit) begin
      blink_cnt = '0;
      led_q = ~led_q;
    end

    case (cmd_q)
      CMD_FWD:   drive_q = (dist_q >= stop_cfg) ? DRIVE_FWD : DRIVE_STOP;
      CMD_BACK:  drive_q = DRIVE_BACK;
      CMD_LEFT:  drive_q = DRIVE_LEFT;
      CMD_RIGHT: drive_q = DRIVE_RIGHT;
      CMD_STOP:  drive_q = DRIVE_STOP;
      CMD_SP60:  duty_q = DUTY_60;
      CMD_SP80:  duty_q = DUTY_80;
      CMD_SP100: duty_q = DUTY_100;
      default: ;
    endcase

    r.trigger      = trig_q;
    r.motor_drive  = drive_q;
    r.duty_compare = duty_q;
    r.led          = led_q;
    r.distance     = dist_q;
    r.obstacle     = (dist_q < stop_cfg);
    return r;
  endfunction

  function automatic result_t status(logic trig, logic [3:0] drive, logic [7:0] duty,
                                     logic led, logic [15:0] range_val, logic obs);
    result_t r;
    r.trigger      = trig;
    r.motor_drive  = drive;
    r.duty_compare = duty;
    r.led          = led;
    r.distance     = range_val;
    r.obstacle     = obs;
    return r;
  endfunction

  task automatic flag_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s at beat %0d: want trig %0b drive %0d duty %0d led %0b dist %0d obs %0b,",
               what, beats_out, want.trigger, want.motor_drive, want.duty_compare,
               want.led, want.distance, want.obstacle,
               " got trig %0b drive %0d duty %0d led %0b dist %0d obs %0b pad %0b",
               got.trigger, got.motor_drive, got.duty_compare, got.led, got.distance,
               got.obstacle, m_axis_tdata[31]);
  endtask

  // Predict on each accepted input beat, check each accepted output beat
  always @(posedge clk) begin : scoreboard
    result_t want;
    result_t got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = compute_status(action_t'(s_axis_tuser), s_axis_tdata[0], s_axis_tdata[8:1]);
        if (fixed_on) want = fixed_status;
        pending_status.push_back(want);
        events_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[RESULT_W-1:0]);
        if (pending_status.size() == 0) begin
          flag_mismatch("unexpected status beat", '0, got);
        end else begin
          want = pending_status.pop_front();
          if (got.trigger !== want.trigger || got.motor_drive !== want.motor_drive ||
              got.duty_compare !== want.duty_compare || got.led !== want.led ||
              got.distance !== want.distance || got.obstacle !== want.obstacle ||
              m_axis_tdata[31] !== 1'b0)
            flag_mismatch("status mismatch", want, got);
        end
        beats_out++;
      end
    end
  end

  // Run length guard
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_cnt, pending_status.size());
    $display("FAIL sonar_guarded_motor_controller");
    $finish;
  end

  // Drive one event beat; entered and left at a falling edge
  task automatic send_event(action_t act, logic lvl, logic [7:0] cmd,
                            bit fixed, result_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, cmd, lvl};
    s_axis_tuser  <= act;
    fixed_on      = fixed;
    fixed_status  = want;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    fixed_on = 1'b0;
  endtask

  // Hold the sender until every pending status beat has drained
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_TRIGGER_PERIOD: period_cfg = val;
      REG_STOP_DISTANCE:  stop_cfg = val;
      REG_BLINK_SCALE:    scale_cfg = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(logic [15:0] period, logic [15:0] stop, logic [7:0] scale);
    write_reg(REG_TRIGGER_PERIOD, period);
    write_reg(REG_STOP_DISTANCE, stop);
    write_reg(REG_BLINK_SCALE, {8'd0, scale});
  endtask

  task automatic add_event(action_t act, logic lvl, logic [7:0] cmd, int reps);
    row_t r;
    r = '{kind: ROW_EVT, act: act, lvl: lvl, cmd: cmd, reps: reps, fixed: 1'b0,
          want: '0, reg_idx: '0, reg_val: '0};
    dir_rows.push_back(r);
  endtask

  task automatic add_fixed(action_t act, logic lvl, logic [7:0] cmd, result_t want);
    row_t r;
    r = '{kind: ROW_EVT, act: act, lvl: lvl, cmd: cmd, reps: 1, fixed: 1'b1,
          want: want, reg_idx: '0, reg_val: '0};
    dir_rows.push_back(r);
  endtask

  task automatic add_write(logic [1:0] idx, logic [15:0] val);
    row_t r;
    r = '{kind: ROW_CFG, act: ACT_NONE, lvl: 1'b0, cmd: '0, reps: 0, fixed: 1'b0,
          want: '0, reg_idx: idx, reg_val: val};
    dir_rows.push_back(r);
  endtask

  // Pick the next random event: mostly whole echo pulses with commands mixed in
  task automatic pick_event(output action_t act, output logic lvl, output logic [7:0] cmd);
    int roll;
    int goal_cap;
    lvl  = 1'($urandom_range(1));
    cmd  = 8'($urandom_range(255));
    roll = $urandom_range(99);
    if (gen_meas && gen_ticks >= gen_goal && $urandom_range(3) != 0) begin
      act = ACT_ECHO;
      lvl = 1'b0;
    end else if (gen_meas) begin
      if (roll < 75)      act = ACT_TICK;
      else if (roll < 93) act = ACT_CMD;
      else if (roll < 97) begin act = ACT_ECHO; lvl = 1'b1; end
      else                act = ACT_NONE;
    end else begin
      if (roll < 40)      act = ACT_TICK;
      else if (roll < 72) act = ACT_CMD;
      else if (roll < 90) begin act = ACT_ECHO; lvl = 1'b1; end
      else if (roll < 95) begin act = ACT_ECHO; lvl = 1'b0; end
      else                act = ACT_NONE;
    end

    // Mostly known command characters, the rest raw bytes
    if (act == ACT_CMD && $urandom_range(4) != 0) begin
      case ($urandom_range(7))
        0: cmd = CMD_FWD;
        1: cmd = CMD_BACK;
        2: cmd = CMD_LEFT;
        3: cmd = CMD_RIGHT;
        4: cmd = CMD_STOP;
        5: cmd = CMD_SP60;
        6: cmd = CMD_SP80;
        default: cmd = CMD_SP100;
      endcase
    end

    // Track the pulse so widths land around the stop distance
    goal_cap = (stop_cfg < 20) ? 2 * int'(stop_cfg) + 6 : 46;
    if (act == ACT_TICK && gen_meas) gen_ticks++;
    if (act == ACT_ECHO && lvl) begin
      gen_meas  = 1'b1;
      gen_ticks = 0;
      gen_goal  = $urandom_range(goal_cap);
    end else if (act == ACT_ECHO) begin
      gen_meas = 1'b0;
    end
  endtask

  initial begin : stimulus
    action_t    act;
    logic       lvl;
    logic [7:0] cmd;

    reset_model();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Reset values; the distance stays zero so the LED flips on every beat
    add_fixed(ACT_TICK, 1'b1, CMD_FWD,
              status(1'b0, DRIVE_STOP,  DUTY_60,  1'b1, 16'd0, 1'b1));
    add_fixed(ACT_CMD,  1'b0, CMD_FWD,
              status(1'b0, DRIVE_STOP,  DUTY_60,  1'b0, 16'd0, 1'b1));
    add_fixed(ACT_CMD,  1'b1, CMD_SP100,
              status(1'b0, DRIVE_STOP,  DUTY_100, 1'b1, 16'd0, 1'b1));
    add_fixed(ACT_CMD,  1'b0, CMD_SP80,
              status(1'b0, DRIVE_STOP,  DUTY_80,  1'b0, 16'd0, 1'b1));
    add_fixed(ACT_CMD,  1'b0, CMD_SP60,
              status(1'b0, DRIVE_STOP,  DUTY_60,  1'b1, 16'd0, 1'b1));
    add_fixed(ACT_CMD,  1'b0, CMD_BACK,
              status(1'b0, DRIVE_BACK,  DUTY_60,  1'b0, 16'd0, 1'b1));
    add_fixed(ACT_CMD,  1'b0, CMD_LEFT,
              status(1'b0, DRIVE_LEFT,  DUTY_60,  1'b1, 16'd0, 1'b1));
    add_fixed(ACT_CMD,  1'b0, CMD_RIGHT,
              status(1'b0, DRIVE_RIGHT, DUTY_60,  1'b0, 16'd0, 1'b1));
    add_fixed(ACT_CMD,  1'b0, 8'hFF,
              status(1'b0, DRIVE_RIGHT, DUTY_60,  1'b1, 16'd0, 1'b1));
    add_fixed(ACT_CMD,  1'b1, 8'h00,
              status(1'b0, DRIVE_RIGHT, DUTY_60,  1'b0, 16'd0, 1'b1));
    add_fixed(ACT_NONE, 1'b1, CMD_BACK,
              status(1'b0, DRIVE_RIGHT, DUTY_60,  1'b1, 16'd0, 1'b1));
    add_fixed(ACT_ECHO, 1'b1, CMD_STOP,
              status(1'b0, DRIVE_RIGHT, DUTY_60,  1'b0, 16'd0, 1'b1));
    // Measure a short pulse, then forward drive at exactly the stop distance
    add_event(ACT_TICK, 1'b0, 8'h00, 4);
    add_event(ACT_ECHO, 1'b0, 8'hFF, 1);
    add_write(REG_STOP_DISTANCE, 16'd4);
    add_write(REG_TRIGGER_PERIOD, 16'd0);
    add_event(ACT_CMD,  1'b0, CMD_FWD, 1);
    add_event(ACT_TICK, 1'b1, 8'hFF, 2);
    // Falling edge with no rising edge latches the stale width
    add_event(ACT_ECHO, 1'b0, 8'h00, 1);
    // Zero-width pulse drops the forward drive
    add_event(ACT_ECHO, 1'b1, 8'h00, 1);
    add_event(ACT_ECHO, 1'b0, 8'h00, 1);
    add_write(REG_BLINK_SCALE, 16'd255);
    add_write(REG_TRIGGER_PERIOD, 16'hFFFF);
    add_write(REG_STOP_DISTANCE, 16'hFFFF);
    add_event(ACT_CMD,  1'b0, CMD_STOP, 1);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        repeat (dir_rows[i].reps)
          send_event(dir_rows[i].act, dir_rows[i].lvl, dir_rows[i].cmd,
                     dir_rows[i].fixed, dir_rows[i].want);
      end
    end
    settle();

    // Random phases over extreme and random register settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(16'd1, 16'd0, 8'd0);
        1: set_config(16'hFFFF, 16'hFFFF, 8'hFF);
        5: set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(65535)),
                      8'($urandom_range(255)));
        default: set_config(16'($urandom_range(1, 24)), 16'($urandom_range(30)),
                            8'($urandom_range(12)));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick_event(act, lvl, cmd);
        send_event(act, lvl, cmd, 1'b0, '0);
        if ((p == 3 && n == PHASE_ITEMS / 2) || $urandom_range(149) == 0) settle();
      end
      settle();
    end

    stall_pct = 0;
    repeat (12) @(negedge clk);

    $display("Covered a directed table of every command, echo case and register extreme,");
    $display("then 8 random phases: %0d events in, %0d status beats checked, %0d mismatches",
             events_in, beats_out, mismatches);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("PASS sonar_guarded_motor_controller");
    end else begin
      $display("FAIL sonar_guarded_motor_controller");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sgmc_pkg.sv
design/sgmc_core.sv
design/sgmc_skid.sv
design/sonar_guarded_motor_controller.sv
design/sgmc_checker.sv
verif/sonar_guarded_motor_controller_tb.sv
